// ===== hdl/round_robin_process_scheduler_top_defines.svh =====
// assertion macros for the round-robin scheduler
// no dependencies; included by the files that carry assertions
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_TOP_DEFINES_SVH

// property holds at every edge out of reset
`define RR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define RR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/rr_sched_pkg.sv =====
// shared types and constants of the round-robin scheduler
// no dependencies; imported by every module of the block
package rr_sched_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PID_BITS    = 8;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef logic [PID_BITS-1:0] pid_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic {
		CMD_ADD    = 1'b0,
		CMD_REPORT = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		OUT_OK       = 2'd0,
		OUT_FINISHED = 2'd1,
		OUT_PAGE     = 2'd2,
		OUT_ERROR    = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_IDLE = 2'd2
	} status_t;

	typedef struct packed {
		logic shift;
		logic wr;
	} cell_ctrl_t;

endpackage

// ===== hdl/rr_sched_cell.sv =====
// one slot of the shifting ready queue
// depends on rr_sched_pkg
module rr_sched_cell (
	input  logic                     clk,
	input  rr_sched_pkg::cell_ctrl_t ctrl,
	input  rr_sched_pkg::pid_t       wr_data,
	input  rr_sched_pkg::pid_t       next_data,
	output rr_sched_pkg::pid_t       data
);
	import rr_sched_pkg::*;

	pid_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			data_q <= wr_data;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

// ===== hdl/rr_sched_queue.sv =====
// fifo ready queue built as a row of shifting cells, head in cell 0
// depends on rr_sched_pkg, rr_sched_cell and the defines header
`include "round_robin_process_scheduler_top_defines.svh"
module rr_sched_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               pop,
	input  rr_sched_pkg::pid_t push_data,
	output rr_sched_pkg::pid_t head,
	output rr_sched_pkg::cnt_t count
);
	import rr_sched_pkg::*;

	cnt_t       count_q;
	cnt_t       wr_pos;
	logic       wr_en;
	pid_t       cell_data [QUEUE_DEPTH];
	pid_t       cell_next [QUEUE_DEPTH];
	cell_ctrl_t cell_ctrl [QUEUE_DEPTH];

	// a push and pop on an empty queue bypasses the cells
	assign wr_en  = push && ((count_q != '0) || !pop);
	assign wr_pos = pop ? count_q - cnt_t'(1) : count_q;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign cell_next[i] = '0;
		end else begin : g_mid
			assign cell_next[i] = cell_data[i+1];
		end
		assign cell_ctrl[i] = '{shift: pop, wr: wr_en && (wr_pos == cnt_t'(i))};
		rr_sched_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl[i]),
			.wr_data   (push_data),
			.next_data (cell_next[i]),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + cnt_t'(push) - cnt_t'(pop);
		end
	end

	assign head  = cell_data[0];
	assign count = count_q;

	`RR_ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= cnt_t'(QUEUE_DEPTH))
	`RR_ASSERT_ALWAYS(a_no_push_full, clk, arst_n,
		!(push && !pop && (count_q == cnt_t'(QUEUE_DEPTH))))
	`RR_ASSERT_NEXT(a_count_hold, clk, arst_n, push == pop, $stable(count_q))

endmodule

// ===== hdl/round_robin_process_scheduler_top.sv =====
// round-robin process scheduler with time slice, top level
// depends on rr_sched_pkg, rr_sched_queue and the defines header
//
// usage
//   input channel: cmd and outcome with in_valid / in_stall; a request is
//   taken at an edge with in_valid high and in_stall low
//   output channel: assigned_pid, running_valid, running_pid and status with
//   out_valid / out_stall; one result per request
//   config channel: cfg_valid / cfg_ready with cfg_data writes time_slice;
//   cfg_ready is always high, write only while the block is idle
//   result: in the output register in the cycle after the request is taken
//   throughput: one request per cycle while the output is drained; the whole
//   step (queue push, shift of the cell row and dispatch) happens in the same cycle
//   stall: a result held by out_stall keeps in_stall high, so no request is
//   taken until that result has gone
//   reset: queue empty, nothing running, id counter zero, time_slice 2
`include "round_robin_process_scheduler_top_defines.svh"
module round_robin_process_scheduler_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd,
	input  logic [1:0] outcome,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] assigned_pid,
	output logic       running_valid,
	output logic [7:0] running_pid,
	output logic [1:0] status,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import rr_sched_pkg::*;

	logic       accept;
	logic [7:0] slice_len_q;
	pid_t       pid_cnt_q;
	logic       cur_valid_q;
	pid_t       cur_pid_q;
	logic [7:0] slice_used_q;

	logic       out_valid_q;
	pid_t       assigned_q;
	logic       running_valid_q;
	pid_t       running_pid_q;
	status_t    status_q;

	logic       push;
	logic       pop;
	pid_t       push_pid;
	pid_t       q_head;
	cnt_t       q_count;
	logic       v_mid;
	logic [8:0] slice_inc;
	logic [7:0] slice_nx;
	pid_t       pid_cnt_nx;
	pid_t       assigned_nx;
	status_t    status_nx;
	logic       cur_valid_nx;
	pid_t       cur_pid_nx;

	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		push        = 1'b0;
		push_pid    = cur_pid_q;
		v_mid       = cur_valid_q;
		slice_nx    = slice_used_q;
		slice_inc   = {1'b0, slice_used_q} + 9'd1;
		status_nx   = ST_OK;
		assigned_nx = '0;
		pid_cnt_nx  = pid_cnt_q;
		if (cmd_t'(cmd) == CMD_ADD) begin
			if (q_count == cnt_t'(QUEUE_DEPTH)) begin
				status_nx = ST_FULL;
			end else begin
				push        = 1'b1;
				push_pid    = pid_cnt_q;
				assigned_nx = pid_cnt_q;
				pid_cnt_nx  = pid_cnt_q + pid_t'(1);
			end
		end else if (!cur_valid_q) begin
			status_nx = ST_IDLE;
		end else begin
			case (outcome_t'(outcome))
				OUT_OK: begin
					if (slice_inc >= {1'b0, slice_len_q}) begin
						push  = 1'b1;
						v_mid = 1'b0;
					end else begin
						slice_nx = slice_inc[7:0];
					end
				end
				OUT_PAGE: begin
					push  = 1'b1;
					v_mid = 1'b0;
				end
				default: begin
					v_mid = 1'b0;
				end
			endcase
		end
		// dispatch the head, or the pushed id itself when the queue is empty
		pop = !v_mid && (push || (q_count != '0));
		if (pop) begin
			cur_valid_nx = 1'b1;
			cur_pid_nx   = (q_count != '0) ? q_head : push_pid;
			slice_nx     = '0;
		end else begin
			cur_valid_nx = v_mid;
			cur_pid_nx   = cur_pid_q;
		end
	end

	rr_sched_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && push),
		.pop       (accept && pop),
		.push_data (push_pid),
		.head      (q_head),
		.count     (q_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_len_q     <= 8'd2;
			pid_cnt_q       <= '0;
			cur_valid_q     <= 1'b0;
			cur_pid_q       <= '0;
			slice_used_q    <= '0;
			out_valid_q     <= 1'b0;
			running_valid_q <= 1'b0;
			status_q        <= ST_OK;
		end else begin
			if (cfg_valid && cfg_ready) begin
				slice_len_q <= cfg_data;
			end
			if (accept) begin
				pid_cnt_q       <= pid_cnt_nx;
				cur_valid_q     <= cur_valid_nx;
				cur_pid_q       <= cur_pid_nx;
				slice_used_q    <= slice_nx;
				out_valid_q     <= 1'b1;
				running_valid_q <= cur_valid_nx;
				status_q        <= status_nx;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			assigned_q    <= assigned_nx;
			running_pid_q <= cur_valid_nx ? cur_pid_nx : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign assigned_pid  = 8'(assigned_q);
	assign running_valid = running_valid_q;
	assign running_pid   = 8'(running_pid_q);
	assign status        = status_q;

	`RR_ASSERT_ALWAYS(a_idle_empty, clk, arst_n, cur_valid_q || (q_count == '0))
	`RR_ASSERT_NEXT(a_pid_hold, clk, arst_n, !accept, $stable(pid_cnt_q))
	`RR_ASSERT_ALWAYS(a_idle_status, clk, arst_n,
		!(out_valid_q && (status_q == ST_IDLE) && running_valid_q))

endmodule
